@@ design/pis_pkg.sv @@
// shared constants and types for the pid controller with integral separation
package pis_pkg;

  localparam int DATA_W      = 16;
  localparam int ERR_W       = DATA_W + 1;
  localparam int DRIVE_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int S_TDATA_W   = 2 * DATA_W;
  localparam int INTEG_W_DEF = 24;

  localparam logic signed [DATA_W-1:0]  GAIN_PROP_RST  = 16'sd256;
  localparam logic signed [DATA_W-1:0]  GAIN_INTEG_RST = 16'sd0;
  localparam logic signed [DATA_W-1:0]  GAIN_DERIV_RST = 16'sd0;
  localparam logic signed [DRIVE_W-1:0] UPPER_RST      = 32'sh7fffffff;
  localparam logic signed [DRIVE_W-1:0] LOWER_RST      = 32'sh80000000;
  // about 0.8 in q8.8
  localparam logic [DATA_W-1:0]         BAND_RST       = 16'd205;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_UPPER      = 3'd3,
    REG_LOWER      = 3'd4,
    REG_BAND       = 3'd5
  } pis_reg_t;

endpackage

@@ design/pid_integral_separation.sv @@
// pid controller with integral separation, one registered step per item
// Each input item (setpoint and measured in signed q8.8, clear flag in tuser)
// is captured in an input register and, once the output register is free, turned into
// one result item (saturated q16.16 drive in tdata, integral-enable flag in
// tuser) held in an output register. The block takes one item every cycle
// unless m_tready stalls the output; the limit is the loop from the previous drive
// through the integral gate, the integral multiply and the final saturation.
// Output valid is set as the item moves into the output register. A clear item
// zeroes the integral and the previous drive and returns a zero drive.
// Registers are written on the cfg channel, which is always ready; indexes
// beyond the register list are ignored.
module pid_integral_separation #(
  parameter int INTEG_WIDTH = pis_pkg::INTEG_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pis_pkg::S_TDATA_W-1:0]    s_tdata,   // setpoint, measured
  input  logic                             s_tuser,   // clear_req
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pis_pkg::DRIVE_W-1:0]      m_tdata,   // drive
  output logic                             m_tuser,   // integ_active
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pis_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pis_pkg::*;

  localparam int IW  = INTEG_WIDTH;
  localparam int IW1 = INTEG_WIDTH + 1;
  localparam int SW  = ((INTEG_WIDTH + DATA_W > 2 * ERR_W) ?
                        INTEG_WIDTH + DATA_W : 2 * ERR_W) + 2;

  localparam logic signed [IW:0]    IMAX = {2'b00, {(IW-1){1'b1}}};
  localparam logic signed [IW:0]    IMIN = {2'b11, {(IW-1){1'b0}}};
  localparam logic signed [SW-1:0]  DMAX = {{(SW-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [SW-1:0]  DMIN = {{(SW-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

  // configuration registers
  logic signed [DATA_W-1:0]  gain_prop, gain_integ, gain_deriv;
  logic signed [DRIVE_W-1:0] upper_limit, lower_limit;
  logic [DATA_W-1:0]         separation_band;

  // loop state
  logic signed [IW-1:0]      integ_sum, integ_sum_next;
  logic signed [ERR_W-1:0]   prev_error;
  logic signed [DRIVE_W-1:0] prev_drive;

  // input register
  logic                      in_valid;
  logic signed [DATA_W-1:0]  in_setpoint, in_measured;
  logic                      in_clear;

  // output register
  logic signed [DRIVE_W-1:0] drive, drive_next;
  logic                      active, active_next;

  logic                      advance;
  logic                      step;
  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          mag;
  logic                      add_ok;
  logic signed [IW:0]        isum_wide;
  logic signed [SW-1:0]      p_prop, p_integ, p_deriv, sum;
  logic signed [ERR_W:0]     derr;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign step      = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop       <= GAIN_PROP_RST;
      gain_integ      <= GAIN_INTEG_RST;
      gain_deriv      <= GAIN_DERIV_RST;
      upper_limit     <= UPPER_RST;
      lower_limit     <= LOWER_RST;
      separation_band <= BAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_PROP:  gain_prop       <= cfg_data[DATA_W-1:0];
        REG_GAIN_INTEG: gain_integ      <= cfg_data[DATA_W-1:0];
        REG_GAIN_DERIV: gain_deriv      <= cfg_data[DATA_W-1:0];
        REG_UPPER:      upper_limit     <= cfg_data[DRIVE_W-1:0];
        REG_LOWER:      lower_limit     <= cfg_data[DRIVE_W-1:0];
        REG_BAND:       separation_band <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_setpoint <= s_tdata[DATA_W-1:0];
      in_measured <= s_tdata[2*DATA_W-1:DATA_W];
      in_clear    <= s_tuser;
    end
  end

  always_comb begin
    err       = ERR_W'(in_setpoint) - ERR_W'(in_measured);
    mag       = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    active_next = !in_clear && (mag < {1'b0, separation_band});
    add_ok    = ((prev_drive > upper_limit) && err[ERR_W-1]) ||
                ((prev_drive < lower_limit) && !err[ERR_W-1] && (err != '0)) ||
                ((prev_drive < upper_limit) && (prev_drive > lower_limit));
    isum_wide = IW1'(integ_sum) + IW1'(err);
    if (in_clear) begin
      integ_sum_next = '0;
    end else if (active_next && add_ok) begin
      if (isum_wide > IMAX) begin
        integ_sum_next = IMAX[IW-1:0];
      end else if (isum_wide < IMIN) begin
        integ_sum_next = IMIN[IW-1:0];
      end else begin
        integ_sum_next = isum_wide[IW-1:0];
      end
    end else begin
      integ_sum_next = integ_sum;
    end
    derr    = (ERR_W+1)'(err) - (ERR_W+1)'(prev_error);
    p_prop  = SW'(gain_prop) * SW'(err);
    p_integ = active_next ? SW'(gain_integ) * SW'(integ_sum_next) : '0;
    p_deriv = SW'(gain_deriv) * SW'(derr);
    sum     = p_prop + p_integ + p_deriv;
    if (in_clear) begin
      drive_next = '0;
    end else if (sum > DMAX) begin
      drive_next = DMAX[DRIVE_W-1:0];
    end else if (sum < DMIN) begin
      drive_next = DMIN[DRIVE_W-1:0];
    end else begin
      drive_next = sum[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_sum  <= '0;
      prev_error <= '0;
      prev_drive <= '0;
    end else if (step) begin
      integ_sum  <= integ_sum_next;
      prev_drive <= drive_next;
      if (!in_clear) begin
        prev_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      drive  <= drive_next;
      active <= active_next;
    end
  end

  assign m_tdata = drive;
  assign m_tuser = active;

`ifndef NO_ASSERTIONS
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (step && in_clear) |=> (m_tdata == '0) && !m_tuser && (integ_sum == '0))
    else $error("clear item did not zero drive and integral");

  a_hold_integ: assert property (@(posedge clk) disable iff (rst)
    (step && !in_clear && !active_next) |=> $stable(integ_sum))
    else $error("integral changed while separated");

  a_prev_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (prev_drive == m_tdata))
    else $error("previous drive out of step with output");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");
`endif

endmodule

@@ verif/pis_checker.sv @@
// checker for the pid controller: predicts each drive item and compares it with the output
module pis_checker
  import pis_pkg::*;
#(
  parameter int INTEG_W = INTEG_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // setpoint, measured
  input  logic                  s_tuser,   // clear_req
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [DRIVE_W-1:0]    m_tdata,   // drive
  input  logic                  m_tuser,   // integ_active
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      integ_active;
  } drive_item_t;

  drive_item_t drive_q[$];

  logic signed [DATA_W-1:0]  kp, ki, kd;
  logic signed [DRIVE_W-1:0] hi_lim, lo_lim;
  logic [DATA_W-1:0]         band;

  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [ERR_W-1:0]   last_err;
  logic signed [DRIVE_W-1:0] last_drive;

  function automatic drive_item_t pid_step(logic signed [DATA_W-1:0] sp,
                                           logic signed [DATA_W-1:0] ms, logic clr);
    drive_item_t r;
    longint err, mag, sum, imax, imin, pd, hi, lo;
    logic en, add;
    imax = (longint'(1) <<< (INTEG_W - 1)) - 1;
    imin = -imax - 1;
    r.drive = '0;
    r.integ_active = 1'b0;
    if (clr) begin
      integ_acc = '0;
      last_drive = '0;
      return r;
    end
    err = longint'(sp) - longint'(ms);
    mag = (err < 0) ? -err : err;
    en = (mag < longint'(band));
    pd = longint'(last_drive);
    hi = longint'(hi_lim);
    lo = longint'(lo_lim);
    if (en) begin
      add = (pd > hi && err < 0) || (pd < lo && err > 0) || (pd < hi && pd > lo);
      if (add) begin
        sum = longint'(integ_acc) + err;
        if (sum > imax) sum = imax;
        if (sum < imin) sum = imin;
        integ_acc = sum[INTEG_W-1:0];
      end
    end
    sum = longint'(kp) * err;
    if (en) sum += longint'(ki) * longint'(integ_acc);
    sum += longint'(kd) * (err - longint'(last_err));
    if (sum > 64'sh7fffffff) sum = 64'sh7fffffff;
    if (sum < -64'sh80000000) sum = -64'sh80000000;
    last_drive = sum[DRIVE_W-1:0];
    last_err = err[ERR_W-1:0];
    r.drive = sum[DRIVE_W-1:0];
    r.integ_active = en;
    return r;
  endfunction

  always @(posedge clk) begin
    drive_item_t got, want;
    if (rst) begin
      kp = GAIN_PROP_RST;
      ki = GAIN_INTEG_RST;
      kd = GAIN_DERIV_RST;
      hi_lim = UPPER_RST;
      lo_lim = LOWER_RST;
      band = BAND_RST;
      integ_acc = '0;
      last_err = '0;
      last_drive = '0;
      drive_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_PROP:  kp = cfg_data[DATA_W-1:0];
          REG_GAIN_INTEG: ki = cfg_data[DATA_W-1:0];
          REG_GAIN_DERIV: kd = cfg_data[DATA_W-1:0];
          REG_UPPER:      hi_lim = cfg_data[DRIVE_W-1:0];
          REG_LOWER:      lo_lim = cfg_data[DRIVE_W-1:0];
          REG_BAND:       band = cfg_data[DATA_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tuser};
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got drive %0d integ_active %0b",
                   $time, $signed(m_tdata), m_tuser);
          errors++;
        end else begin
          want = drive_q.pop_front();
          if (got.drive !== want.drive) begin
            $display("%0t: drive expected %0d, got %0d", $time, want.drive, got.drive);
            errors++;
          end
          if (got.integ_active !== want.integ_active) begin
            $display("%0t: integ_active expected %0b, got %0b", $time,
                     want.integ_active, got.integ_active);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        drive_q.push_back(pid_step(s_tdata[DATA_W-1:0], s_tdata[S_TDATA_W-1:DATA_W], s_tuser));
    end
    pending <= drive_q.size();
  end

endmodule

@@ verif/tb.sv @@
// testbench top for the pid controller: clock, reset, stimulus, flow control and verdict
module tb;
  import pis_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;   // setpoint, measured
  logic                  s_tuser;   // clear_req
  logic                  m_tvalid;
  logic                  m_tready;
  logic [DRIVE_W-1:0]    m_tdata;   // drive
  logic                  m_tuser;   // integ_active
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending;
  int quiet;
  int cur_band;
  bit steady;
  bit hold_req;

  pid_integral_separation dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pis_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog on cycles without any accepted item or register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side flow control
  initial begin
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic signed [15:0] kp, input logic signed [15:0] ki,
                           input logic signed [15:0] kd, input logic signed [31:0] hi,
                           input logic signed [31:0] lo, input logic [15:0] band);
    write_reg(REG_GAIN_PROP, {16'($urandom), kp});
    write_reg(REG_GAIN_INTEG, {16'($urandom), ki});
    write_reg(REG_GAIN_DERIV, {16'($urandom), kd});
    write_reg(REG_UPPER, hi);
    write_reg(REG_LOWER, lo);
    write_reg(REG_BAND, {16'($urandom), band});
    cur_band = int'(band);
  endtask

  function automatic logic signed [15:0] rand_gain();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 16'sh7fff;
    if (pick < 15) return 16'sh8000;
    if (pick < 50) return 16'($urandom);
    return 16'(int'($urandom_range(0, 1023)) - 512);
  endfunction

  function automatic logic signed [31:0] rand_limit();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 32'sh7fffffff;
    if (pick < 20) return 32'sh80000000;
    if (pick < 30) return 32'($urandom);
    return 32'(int'($urandom_range(0, 8388608)) - 4194304);
  endfunction

  task automatic load_random();
    logic signed [31:0] hi, lo, t;
    logic [15:0] band;
    int pick;
    hi = rand_limit();
    lo = rand_limit();
    if (lo > hi && $urandom_range(0, 3) != 0) begin
      t = hi;
      hi = lo;
      lo = t;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) band = 16'd0;
    else if (pick < 16) band = 16'hffff;
    else band = 16'($urandom_range(0, 4096));
    load_regs(rand_gain(), rand_gain(), rand_gain(), hi, lo, band);
  endtask

  task automatic send_item(input logic signed [15:0] sp, input logic signed [15:0] ms,
                           input logic clr);
    if (!steady && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ms, sp};
    s_tuser <= clr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // picks a measured value so that setpoint minus measured equals err
  task automatic send_err(input int err);
    int lo_ms, hi_ms, ms;
    lo_ms = (err > 0) ? -32768 : -32768 - err;
    hi_ms = (err > 0) ? 32767 - err : 32767;
    ms = lo_ms + int'($urandom_range(0, hi_ms - lo_ms));
    send_item(16'(ms + err), 16'(ms), 1'b0);
  endtask

  task automatic send_random();
    int pick, span;
    pick = $urandom_range(0, 99);
    span = (cur_band + 8 > 65535) ? 65535 : cur_band + 8;
    if (pick < 3) send_item(16'($urandom), 16'($urandom), 1'b1);
    else if (pick < 18) send_item(16'($urandom), 16'($urandom), 1'b0);
    else send_err(int'($urandom_range(0, 2 * span)) - span);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    cur_band = int'(BAND_RST);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gating around small limits, band edge, clear
    load_regs(16'sd256, 16'sd256, 16'sd256, 32'sh00010000, 32'shffff0000, 16'd512);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    send_item(16'sh7fff, 16'sh8000, 1'b0);
    send_item(16'sh8000, 16'sh7fff, 1'b0);
    send_item(16'sd0, 16'sd0, 1'b0);
    send_item(16'sd100, 16'sd0, 1'b0);
    send_item(16'sd0, 16'sd100, 1'b0);
    send_item(-16'sd5, 16'sd5, 1'b0);
    send_item(16'sd1234, -16'sd99, 1'b1);
    send_item(16'sd50, 16'sd0, 1'b0);
    send_item(16'sd50, 16'sd0, 1'b0);
    send_item(16'sd0, -16'sd511, 1'b0);
    send_item(16'sd0, -16'sd512, 1'b0);
    wait_idle();

    // drive saturation both ways with extreme gains
    load_regs(16'sh7fff, 16'sh8000, 16'sh7fff, 32'sh7fffffff, 32'sh80000000, 16'd0);
    send_item(16'sh7fff, 16'sh8000, 1'b0);
    send_item(16'sh8000, 16'sh7fff, 1'b0);
    send_item(16'sd0, 16'sd0, 1'b0);
    wait_idle();

    // previous drive landing exactly on a limit
    load_regs(16'sd256, 16'sd0, 16'sd0, 32'sd256, -32'sd256, 16'hffff);
    send_item(16'sd0, 16'sd0, 1'b1);
    send_item(16'sd1, 16'sd0, 1'b0);
    send_item(16'sd1, 16'sd0, 1'b0);
    send_item(-16'sd1, 16'sd0, 1'b0);
    send_item(-16'sd1, 16'sd0, 1'b0);
    send_item(16'sd0, 16'sd0, 1'b0);
    wait_idle();

    // integral windup: runs of large positive, then large negative errors
    load_regs(16'sd0, 16'sd1, 16'sd0, 32'sh7fffffff, 32'sh80000000, 16'hffff);
    for (int i = 0; i < 160; i++) send_err(int'($urandom_range(50000, 65534)));
    for (int i = 0; i < 160; i++) send_err(-int'($urandom_range(50000, 65534)));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      load_random();
      steady = (ph == 1);
      for (int i = 0; i < 120; i++) begin
        if (ph == 2 && i == 30) hold_req = 1'b1;
        if (ph == 2 && i == 80) wait_idle();
        send_random();
      end
      wait_idle();
    end
    steady = 1'b0;

    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
